// ===== rtl/scmte_pkg.sv =====
// Shared types, constants and command codes for the S-curve move time estimator.
`timescale 1ns / 1ps
package scmte_pkg;

  // Bisection length for the reachable peak speed search.
  localparam int SEARCH_STEPS = 20;
  localparam int STEP_W       = $clog2(SEARCH_STEPS + 1);

  // Lowest speed used as a cruise divisor, 0.001 mm/s in Q16.16.
  localparam logic [31:0] MIN_DIV_SPEED = 32'd66;

  // Register reset values (Q24.8).
  localparam logic [31:0] START_ACCEL_RESET = 32'd0;
  localparam logic [31:0] MAX_ACCEL_RESET   = 32'd1024000;
  localparam logic [31:0] JERK_LIMIT_RESET  = 32'd25600000;

  // Serial divider and square root sizes.
  localparam int NUM_W   = 72;
  localparam int DEN_W   = 33;
  localparam int NCNT_W  = $clog2(NUM_W + 1);
  localparam int SQ_W    = 64;
  localparam int ROOT_W  = 32;

  // Dividend lengths of the different divisions.
  localparam logic [NCNT_W-1:0] N_DVJ  = NCNT_W'(72);
  localparam logic [NCNT_W-1:0] N_TC   = NCNT_W'(48);
  localparam logic [NCNT_W-1:0] N_TA_A = NCNT_W'(41);
  localparam logic [NCNT_W-1:0] N_TA_B = NCNT_W'(40);
  localparam logic [NCNT_W-1:0] N_FIN  = NCNT_W'(48);

  typedef enum logic [1:0] {
    CFG_START_ACCEL = 2'd0,
    CFG_MAX_ACCEL   = 2'd1,
    CFG_JERK_LIMIT  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [31:0] feedrate;
    logic [31:0] distance;
  } in_item_t;

  typedef struct packed {
    logic [31:0] move_time;
    logic        saturated;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_AMSQ, ST_A0SQ, ST_SUBD, ST_DVJ_GO, ST_DVJ_WAIT,
    ST_TC_GO, ST_TC_WAIT, ST_EVAL, ST_JV, ST_SQ_GO, ST_SQ_WAIT, ST_DA_GO,
    ST_DA_WAIT, ST_DB_GO, ST_DB_WAIT, ST_RLO, ST_RHI, ST_RCMP, ST_BRANCH,
    ST_MID, ST_F_GO, ST_F_WAIT, ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    PH_FIRST, PH_BIS, PH_LAST
  } phase_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MUL_AMSQ, OP_MUL_A0SQ, OP_SUBD, OP_DIV_DVJ,
    OP_DVJ_STORE, OP_DIV_TC, OP_TC_STORE, OP_TA_ZERO, OP_MUL_JV, OP_SQRT_GO,
    OP_DIV_A, OP_TA_FROM_A, OP_DIV_B, OP_TA_FROM_B, OP_MUL_RLO, OP_MUL_RHI,
    OP_RCMP, OP_BIS_INIT, OP_BIS_UPD, OP_V_MID, OP_V_LO, OP_DIV_F_FEED,
    OP_DIV_F_LO, OP_TIME_SUM, OP_OUT_LOAD
  } dp_op_t;

  typedef struct packed {
    logic zero_move;
    logic v_zero;
    logic case_a;
    logic r_le;
    logic div_busy;
    logic sqrt_busy;
  } dp_status_t;

endpackage

// ===== rtl/scmte_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module scmte_div
  import scmte_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num_in,
  input  logic [DEN_W-1:0]  den_in,
  input  logic [NCNT_W-1:0] nbits,
  output logic              busy,
  output logic [NUM_W-1:0]  quot
);

  logic [NUM_W-1:0]  num;
  logic [DEN_W-1:0]  den;
  logic [DEN_W-1:0]  rem;
  logic [NCNT_W-1:0] cnt;
  logic [DEN_W:0]    trial;
  logic              ge;

  // The dividend arrives left aligned, so its top bit enters first.
  assign trial = {rem, num[NUM_W-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == NCNT_W'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num  <= num_in;
      den  <= den_in;
      rem  <= '0;
      quot <= '0;
      cnt  <= nbits;
    end else if (busy) begin
      num  <= {num[NUM_W-2:0], 1'b0};
      rem  <= ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      quot <= {quot[NUM_W-2:0], ge};
      cnt  <= cnt - NCNT_W'(1);
    end
  end

endmodule

// ===== rtl/scmte_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
`timescale 1ns / 1ps
module scmte_sqrt
  import scmte_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   x_in,
  output logic              busy,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [SQ_W-1:0]  x;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [REM_W+1:0] acc;
  logic [REM_W+1:0] trial;
  logic             ge;

  assign acc   = {rem, x[SQ_W-1:SQ_W-2]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = acc >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CNT_W'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= x_in;
      rem  <= '0;
      root <= '0;
      cnt  <= CNT_W'(ROOT_W);
    end else if (busy) begin
      x    <= {x[SQ_W-3:0], 2'b00};
      rem  <= ge ? REM_W'(acc - trial) : acc[REM_W-1:0];
      root <= {root[ROOT_W-2:0], ge};
      cnt  <= cnt - CNT_W'(1);
    end
  end

endmodule

// ===== rtl/scmte_datapath.sv =====
// Datapath: operand registers, shared multiplier, divider and square root.
`timescale 1ns / 1ps
module scmte_datapath
  import scmte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dp_op_t      op,
  input  in_item_t    in_data,
  input  logic [31:0] start_accel,
  input  logic [31:0] max_accel,
  input  logic [31:0] jerk_limit,
  output dp_status_t  status,
  output out_item_t   out_data
);

  logic [31:0] am, jk, a0;
  logic [31:0] feed, move_dist, v, lo, hi, cruise;
  logic [63:0] prod, plo, d, a0sq, dvj;
  logic [47:0] tc;
  logic [49:0] ta;
  logic [51:0] t;
  logic        zero_move, r_le;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [32:0] mid_sum;
  logic [48:0] r_sum;
  logic        r_fit;

  logic              div_start, div_busy;
  logic [NUM_W-1:0]  div_num, quot;
  logic [DEN_W-1:0]  div_den, sq_den;
  logic [NCNT_W-1:0] div_n;
  logic              sqrt_start, sqrt_busy;
  logic [ROOT_W-1:0] root;
  logic [SQ_W-1:0]   sqrt_x;

  // Effective register values: zero is lifted to one, start clamped to max.
  assign am = (max_accel == 32'd0) ? 32'd1 : max_accel;
  assign jk = (jerk_limit == 32'd0) ? 32'd1 : jerk_limit;
  assign a0 = (start_accel > am) ? am : start_accel;

  always_comb begin
    mul_a = v;
    mul_b = 32'd0;
    case (op)
      OP_MUL_AMSQ: begin mul_a = am; mul_b = am; end
      OP_MUL_A0SQ: begin mul_a = a0; mul_b = a0; end
      OP_MUL_JV:   begin mul_a = jk; mul_b = v; end
      OP_MUL_RLO:  begin mul_a = v;  mul_b = ta[31:0]; end
      OP_MUL_RHI:  begin mul_a = v;  mul_b = {14'd0, ta[49:32]}; end
      default:     begin mul_a = v;  mul_b = 32'd0; end
    endcase
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  assign sq_den = ({1'b0, root} + {1'b0, a0} == 33'd0) ? 33'd1
                                                       : {1'b0, root} + {1'b0, a0};

  // Dividends are left aligned in the divider's shift register.
  always_comb begin
    div_start = 1'b1;
    div_num   = '0;
    div_den   = '0;
    div_n     = N_DVJ;
    case (op)
      OP_DIV_DVJ: begin
        div_num = {d, 8'd0};
        div_den = {1'b0, jk};
        div_n   = N_DVJ;
      end
      OP_DIV_TC: begin
        div_num = {am - a0, 40'd0};
        div_den = {1'b0, jk};
        div_n   = N_TC;
      end
      OP_DIV_A: begin
        div_num = {v, 40'd0};
        div_den = sq_den;
        div_n   = N_TA_A;
      end
      OP_DIV_B: begin
        div_num = {v - dvj[31:0], 40'd0};
        div_den = {1'b0, am};
        div_n   = N_TA_B;
      end
      OP_DIV_F_FEED: begin
        div_num = {cruise, 40'd0};
        div_den = {1'b0, feed};
        div_n   = N_FIN;
      end
      OP_DIV_F_LO: begin
        div_num = {cruise, 40'd0};
        div_den = {1'b0, (lo > MIN_DIV_SPEED) ? lo : MIN_DIV_SPEED};
        div_n   = N_FIN;
      end
      default: div_start = 1'b0;
    endcase
  end

  assign sqrt_start = (op == OP_SQRT_GO);
  assign sqrt_x     = {8'd0, prod[63:8]} + a0sq;

  scmte_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num_in (div_num),
    .den_in (div_den),
    .nbits  (div_n),
    .busy   (div_busy),
    .quot   (quot)
  );

  scmte_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .x_in  (sqrt_x),
    .busy  (sqrt_busy),
    .root  (root)
  );

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  // Ramp distance is (high word << 16) + (low word >> 16); it can only fit the
  // distance when that sum stays below 2^32.
  assign r_sum   = {17'd0, prod[15:0], 16'd0} + {1'b0, plo[63:16]};
  assign r_fit   = (prod[63:16] == 48'd0) && (r_sum[48:32] == 17'd0) &&
                   (r_sum[31:0] <= move_dist);

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        feed      <= in_data.feedrate;
        move_dist <= in_data.distance;
        v         <= in_data.feedrate;
        t         <= '0;
        zero_move <= (in_data.feedrate == 32'd0) || (in_data.distance == 32'd0);
      end
      OP_MUL_AMSQ, OP_MUL_JV, OP_MUL_RLO: prod <= mul_p;
      OP_MUL_A0SQ: begin
        prod <= mul_p;
        d    <= prod;
      end
      OP_SUBD: begin
        d    <= d - prod;
        a0sq <= prod;
      end
      OP_DVJ_STORE: dvj <= (quot[71:64] != 8'd0) ? '1 : quot[63:0];
      OP_TC_STORE:  tc <= quot[47:0];
      OP_TA_ZERO:   ta <= '0;
      OP_TA_FROM_A: ta <= {9'd0, quot[40:0]};
      OP_TA_FROM_B: ta <= {1'b0, tc, 1'b0} + {10'd0, quot[39:0]};
      OP_MUL_RHI: begin
        plo  <= prod;
        prod <= mul_p;
      end
      OP_RCMP: begin
        r_le   <= r_fit;
        cruise <= r_fit ? move_dist - r_sum[31:0] : 32'd0;
      end
      OP_BIS_INIT: begin
        lo <= 32'd0;
        hi <= feed;
        v  <= {1'b0, feed[31:1]};
      end
      OP_BIS_UPD: begin
        if (r_le) begin
          lo <= v;
        end else begin
          hi <= v;
        end
      end
      OP_V_MID:    v <= mid_sum[32:1];
      OP_V_LO:     v <= lo;
      OP_TIME_SUM: t <= {1'b0, ta, 1'b0} + {4'd0, quot[47:0]};
      OP_OUT_LOAD: begin
        out_data.saturated <= (t[51:32] != 20'd0);
        out_data.move_time <= (t[51:32] != 20'd0) ? 32'hFFFF_FFFF : t[31:0];
      end
      default: ;
    endcase
  end

  assign status.zero_move = zero_move;
  assign status.v_zero    = (v == 32'd0);
  assign status.case_a    = (dvj >= {32'd0, v});
  assign status.r_le      = r_le;
  assign status.div_busy  = div_busy;
  assign status.sqrt_busy = sqrt_busy;

endmodule

// ===== rtl/scmte_ctrl.sv =====
// Controller: sequences setup, ramp evaluations, bisection and final time.
`timescale 1ns / 1ps
module scmte_ctrl
  import scmte_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output logic       in_stall,
  output logic       out_valid,
  output dp_op_t     op
);

  state_t            state, state_next;
  phase_t            phase;
  logic [STEP_W-1:0] count;
  logic              steps_done, out_free;

  assign steps_done = (count == STEP_W'(SEARCH_STEPS));
  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_valid) state_next = ST_CHECK;
      ST_CHECK:    state_next = status.zero_move ? ST_FINISH : ST_AMSQ;
      ST_AMSQ:     state_next = ST_A0SQ;
      ST_A0SQ:     state_next = ST_SUBD;
      ST_SUBD:     state_next = ST_DVJ_GO;
      ST_DVJ_GO:   state_next = ST_DVJ_WAIT;
      ST_DVJ_WAIT: if (!status.div_busy) state_next = ST_TC_GO;
      ST_TC_GO:    state_next = ST_TC_WAIT;
      ST_TC_WAIT:  if (!status.div_busy) state_next = ST_EVAL;
      ST_EVAL: begin
        if (status.v_zero) begin
          state_next = ST_RLO;
        end else if (status.case_a) begin
          state_next = ST_JV;
        end else begin
          state_next = ST_DB_GO;
        end
      end
      ST_JV:       state_next = ST_SQ_GO;
      ST_SQ_GO:    state_next = ST_SQ_WAIT;
      ST_SQ_WAIT:  if (!status.sqrt_busy) state_next = ST_DA_GO;
      ST_DA_GO:    state_next = ST_DA_WAIT;
      ST_DA_WAIT:  if (!status.div_busy) state_next = ST_RLO;
      ST_DB_GO:    state_next = ST_DB_WAIT;
      ST_DB_WAIT:  if (!status.div_busy) state_next = ST_RLO;
      ST_RLO:      state_next = ST_RHI;
      ST_RHI:      state_next = ST_RCMP;
      ST_RCMP:     state_next = ST_BRANCH;
      ST_BRANCH: begin
        case (phase)
          PH_FIRST: state_next = status.r_le ? ST_F_GO : ST_EVAL;
          PH_BIS:   state_next = ST_MID;
          default:  state_next = ST_F_GO;
        endcase
      end
      ST_MID:      state_next = ST_EVAL;
      ST_F_GO:     state_next = ST_F_WAIT;
      ST_F_WAIT:   if (!status.div_busy) state_next = ST_FINISH;
      ST_FINISH:   if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    op = OP_NONE;
    case (state)
      ST_IDLE:     if (in_valid) op = OP_LOAD;
      ST_AMSQ:     op = OP_MUL_AMSQ;
      ST_A0SQ:     op = OP_MUL_A0SQ;
      ST_SUBD:     op = OP_SUBD;
      ST_DVJ_GO:   op = OP_DIV_DVJ;
      ST_DVJ_WAIT: if (!status.div_busy) op = OP_DVJ_STORE;
      ST_TC_GO:    op = OP_DIV_TC;
      ST_TC_WAIT:  if (!status.div_busy) op = OP_TC_STORE;
      ST_EVAL:     if (status.v_zero) op = OP_TA_ZERO;
      ST_JV:       op = OP_MUL_JV;
      ST_SQ_GO:    op = OP_SQRT_GO;
      ST_DA_GO:    op = OP_DIV_A;
      ST_DA_WAIT:  if (!status.div_busy) op = OP_TA_FROM_A;
      ST_DB_GO:    op = OP_DIV_B;
      ST_DB_WAIT:  if (!status.div_busy) op = OP_TA_FROM_B;
      ST_RLO:      op = OP_MUL_RLO;
      ST_RHI:      op = OP_MUL_RHI;
      ST_RCMP:     op = OP_RCMP;
      ST_BRANCH: begin
        if (phase == PH_FIRST && !status.r_le) begin
          op = OP_BIS_INIT;
        end else if (phase == PH_BIS) begin
          op = OP_BIS_UPD;
        end
      end
      ST_MID:      op = steps_done ? OP_V_LO : OP_V_MID;
      ST_F_GO:     op = (phase == PH_FIRST) ? OP_DIV_F_FEED : OP_DIV_F_LO;
      ST_F_WAIT:   if (!status.div_busy) op = OP_TIME_SUM;
      ST_FINISH:   if (out_free) op = OP_OUT_LOAD;
      default:     op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_FIRST;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_IDLE && in_valid) begin
        phase <= PH_FIRST;
      end else if (state == ST_BRANCH && phase == PH_FIRST && !status.r_le) begin
        phase <= PH_BIS;
        count <= '0;
      end else if (state == ST_BRANCH && phase == PH_BIS) begin
        count <= count + STEP_W'(1);
      end else if (state == ST_MID && steps_done) begin
        phase <= PH_LAST;
      end
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/s_curve_move_time_estimator.sv =====
// Top level of the S-curve move time estimator: registers, controller, datapath.
`timescale 1ns / 1ps
// One move (feedrate, distance) is taken per transfer and one result comes
// back: the time of a rest-to-rest move with symmetric jerk-limited S-curve
// ramps, in unsigned Q16.16 seconds, clipped to all ones with the saturated
// flag set when it overflows. A zero feedrate or distance gives zero at once.
// Otherwise a move runs a setup of two products and two serial divisions on
// the jerk limit, then one ramp evaluation at the feedrate and, when the ramps
// do not fit the distance, SEARCH_STEPS bisection evaluations plus one more at
// the found speed, and a last serial division for the cruise time. A ramp
// evaluation is shorter when the ramp has a constant acceleration phase than
// when it is triangular, since that needs a 32-step square root and a 41-step
// division. These serial steps run on the single shared divider and the
// square root unit, each one bit per cycle. One item is in work at a time;
// the next move is taken as soon as the result sits in the output register,
// even if the receiver still stalls it.
module s_curve_move_time_estimator
  import scmte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] start_accel;
  logic [31:0] max_accel;
  logic [31:0] jerk_limit;
  dp_op_t      op;
  dp_status_t  status;

  // Register writes are always taken; an index beyond the list is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_accel <= START_ACCEL_RESET;
      max_accel   <= MAX_ACCEL_RESET;
      jerk_limit  <= JERK_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_START_ACCEL: start_accel <= cfg_data;
        CFG_MAX_ACCEL:   max_accel   <= cfg_data;
        CFG_JERK_LIMIT:  jerk_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The controller walks the sequence, at most one datapath command a cycle.
  scmte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .op        (op)
  );

  // The datapath holds the operands and the result register.
  scmte_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .in_data     (in_data),
    .start_accel (start_accel),
    .max_accel   (max_accel),
    .jerk_limit  (jerk_limit),
    .status      (status),
    .out_data    (out_data)
  );

endmodule

// ===== rtl/scmte_check.sv =====
// Port-level checker for the move time estimator, bound to the top level.
`timescale 1ns / 1ps
module scmte_check
  import scmte_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data,
  input logic      cfg_valid,
  input logic      cfg_ready
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // A saturated result always reads as the largest time.
  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturated |-> out_data.move_time == 32'hFFFF_FFFF)
    else $error("saturated flag without clipped time");

  // After a move is taken the block works on it and takes no other.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second move taken while one is in work");

  // Register writes are never held off.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("register write not taken");

endmodule

bind s_curve_move_time_estimator scmte_check u_check (.*);
